// ===== design/visca_reply_zoom_decoder_macros.svh =====
// assertion macros for the reply decoder checker
`ifndef VISCA_REPLY_ZOOM_DECODER_MACROS_SVH
`define VISCA_REPLY_ZOOM_DECODER_MACROS_SVH
`define VRZ_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("check failed");
`define VRZ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/vrzd_pkg.sv =====
`timescale 1ns / 1ps
package vrzd_pkg;
  localparam int MaxCurvePoints = 12;
  localparam int NumCfgRegs = 8;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_COMP = 2'd1,
    KIND_POS  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_TARGET_ID = 3'd0,
    CFG_COUNT     = 3'd1,
    CFG_POS_LOW   = 3'd2,
    CFG_POS_MID   = 3'd3,
    CFG_POS_HIGH  = 3'd4,
    CFG_MAG_LOW   = 3'd5,
    CFG_MAG_MID   = 3'd6,
    CFG_MAG_HIGH  = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  low_nibble;
    logic [15:0] zoom_position;
  } job_t;

  localparam logic [7:0] HeadByte  = 8'h90;
  localparam logic [7:0] TailByte  = 8'hFF;
  localparam logic [3:0] HiAck     = 4'h4;
  localparam logic [3:0] HiComp    = 4'h5;
  localparam logic [3:0] HiErr     = 4'h6;
endpackage

// ===== design/visca_reply_zoom_decoder.sv =====
`timescale 1ns / 1ps
// acks, completions and errors: back goes from idle straight to the output state
// position replies: up to 11 curve scan steps, then 1 multiply, 32 divide steps to interpolate
// throughput: one byte per cycle while the result queue has room, else input stalls
// reset: synchronous active-low rst_n clears packet state, queue and registers to defaults
module visca_reply_zoom_decoder #(
  parameter int MAX_CURVE_POINTS = vrzd_pkg::MaxCurvePoints
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // data_byte, source_id
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // reply_kind, low_nibble, zoom_position, magnification
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [7:0]  tid_r;
  logic [3:0]  cnt_r;
  logic [191:0] pos_r, mag_r;
  logic        job_valid, job_ready;
  vrzd_pkg::job_t job;
  logic [39:0] raw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_r <= 8'd11;
      cnt_r <= 4'd10;
      pos_r <= {64'd1073757825, 64'd4351948069680263595, 64'd2938356911949873152};
      mag_r <= {64'd167774464, 64'd576468448985482496, 64'd288233674720149760};
    end else if (cfg_valid) begin
      unique case (vrzd_pkg::cfg_idx_t'(cfg_index))
        vrzd_pkg::CFG_TARGET_ID: tid_r <= cfg_data[7:0];
        vrzd_pkg::CFG_COUNT:     cnt_r <= cfg_data[3:0];
        vrzd_pkg::CFG_POS_LOW:   pos_r[63:0] <= cfg_data;
        vrzd_pkg::CFG_POS_MID:   pos_r[127:64] <= cfg_data;
        vrzd_pkg::CFG_POS_HIGH:  pos_r[191:128] <= cfg_data;
        vrzd_pkg::CFG_MAG_LOW:   mag_r[63:0] <= cfg_data;
        vrzd_pkg::CFG_MAG_MID:   mag_r[127:64] <= cfg_data;
        vrzd_pkg::CFG_MAG_HIGH:  mag_r[191:128] <= cfg_data;
        default: ;
      endcase
    end
  end

  vrzd_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .data_byte(in_tdata[7:0]), .source_id(in_tdata[15:8]), .end_of_packet(in_tlast),
    .target_id(tid_r),
    .job_valid, .job_ready, .job
  );

  vrzd_back #(.MAX_CURVE_POINTS(MAX_CURVE_POINTS)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .point_count(cnt_r),
    .pos_flat(pos_r[MAX_CURVE_POINTS*16-1:0]),
    .mag_flat(mag_r[MAX_CURVE_POINTS*16-1:0]),
    .out_tvalid, .out_tready, .out_tdata(raw)
  );

  assign out_tdata = {raw[39:6], raw[5:2], raw[1:0]};
endmodule

// ===== design/vrzd_front.sv =====
`timescale 1ns / 1ps
module vrzd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        source_id,
  input  logic              end_of_packet,
  input  logic [7:0]        target_id,
  output logic              job_valid,
  input  logic              job_ready,
  output vrzd_pkg::job_t    job
);
  logic [3:0]  cnt_r;
  logic        match_r;
  logic        head_r;
  logic [7:0]  second_r;
  logic        clean_r;
  logic [15:0] acc_r;
  logic        q_valid_r;
  vrzd_pkg::job_t q_r;

  logic        fire;
  logic [3:0]  len;
  logic        m_v, h_v, c_v;
  logic [7:0]  s_v;
  logic [15:0] a_v;
  logic        emit;
  vrzd_pkg::job_t j_v;

  assign in_ready  = !q_valid_r || job_ready;
  assign fire      = in_valid && in_ready;
  assign job_valid = q_valid_r;
  assign job       = q_r;

  always_comb begin
    m_v = match_r;
    h_v = head_r;
    s_v = second_r;
    c_v = clean_r;
    a_v = acc_r;
    if (cnt_r == 4'd0) begin
      m_v = (source_id == target_id);
      h_v = (data_byte == vrzd_pkg::HeadByte);
    end else if (cnt_r == 4'd1) begin
      s_v = data_byte;
    end else if (cnt_r <= 4'd5) begin
      if (data_byte[7:4] != 4'd0) c_v = 1'b0;
      a_v = {acc_r[11:0], data_byte[3:0]};
    end
    len = (cnt_r == 4'd15) ? cnt_r : cnt_r + 4'd1;
    emit = 1'b0;
    j_v.kind = vrzd_pkg::KIND_ACK;
    j_v.low_nibble = s_v[3:0];
    j_v.zoom_position = 16'd0;
    if (m_v && len >= 4'd3 && h_v && data_byte == vrzd_pkg::TailByte) begin
      priority if (s_v[7:4] == vrzd_pkg::HiAck) begin
        emit = 1'b1;
      end else if (s_v[7:4] == vrzd_pkg::HiComp && len == 4'd3) begin
        emit = 1'b1;
        j_v.kind = vrzd_pkg::KIND_COMP;
      end else if (s_v[7:4] == vrzd_pkg::HiComp && len == 4'd7 && c_v) begin
        emit = 1'b1;
        j_v.kind = vrzd_pkg::KIND_POS;
        j_v.zoom_position = a_v;
      end else if (s_v[7:4] == vrzd_pkg::HiErr) begin
        emit = 1'b1;
        j_v.kind = vrzd_pkg::KIND_ERR;
      end else begin
        emit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      match_r <= 1'b0;
      head_r <= 1'b0;
      second_r <= '0;
      clean_r <= 1'b1;
      acc_r <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (fire && end_of_packet && emit) q_valid_r <= 1'b1;
      else if (job_ready) q_valid_r <= 1'b0;
      if (fire) begin
        if (end_of_packet) begin
          cnt_r <= '0;
          match_r <= 1'b0;
          head_r <= 1'b0;
          second_r <= '0;
          clean_r <= 1'b1;
          acc_r <= '0;
        end else begin
          cnt_r <= len;
          match_r <= m_v;
          head_r <= h_v;
          second_r <= s_v;
          clean_r <= c_v;
          acc_r <= a_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && end_of_packet && emit) q_r <= j_v;
  end
endmodule

// ===== design/vrzd_back.sv =====
`timescale 1ns / 1ps
module vrzd_back #(
  parameter int MAX_CURVE_POINTS = vrzd_pkg::MaxCurvePoints
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  vrzd_pkg::job_t                job,
  input  logic [3:0]                    point_count,
  input  logic [MAX_CURVE_POINTS*16-1:0] pos_flat,
  input  logic [MAX_CURVE_POINTS*16-1:0] mag_flat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata
);
  localparam int IW = $clog2(MAX_CURVE_POINTS);

  vrzd_pkg::back_state_t st_r, st_nxt;
  vrzd_pkg::job_t job_r;
  logic [15:0] mag_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] last_idx;
  logic [15:0] p0, p1, m0, m1, pl, ml, pf, mf;
  logic [15:0] zp;
  logic [15:0] num_r, rem_r, den_r;
  logic [15:0] q_r;
  logic [15:0] q_step;
  logic [4:0] bit_r;
  logic neg_r;
  logic [15:0] pdiff_r;
  logic [17:0] trial;
  logic [31:0] dividend_r;
  logic [15:0] out_mag;

  always_comb begin
    if (point_count < 4'd2) last_idx = IW'(1);
    else if (32'(point_count) > MAX_CURVE_POINTS) last_idx = IW'(MAX_CURVE_POINTS - 1);
    else last_idx = IW'(point_count - 4'd1);
  end

  assign zp = job_r.zoom_position;
  assign pf = pos_flat[15:0];
  assign mf = mag_flat[15:0];
  assign pl = pos_flat[16*last_idx +: 16];
  assign ml = mag_flat[16*last_idx +: 16];
  assign p0 = pos_flat[16*idx_r +: 16];
  assign p1 = pos_flat[16*(IW'(idx_r + IW'(1))) +: 16];
  assign m0 = mag_flat[16*idx_r +: 16];
  assign m1 = mag_flat[16*(IW'(idx_r + IW'(1))) +: 16];
  assign trial  = {1'b0, rem_r, dividend_r[31]} - {2'b00, den_r};
  assign q_step = {q_r[14:0], !trial[17]};

  assign job_ready  = (st_r == vrzd_pkg::ST_IDLE);
  assign out_tvalid = (st_r == vrzd_pkg::ST_OUT);
  assign out_mag    = (job_r.kind == vrzd_pkg::KIND_POS) ? mag_r : 16'd0;
  assign out_tdata  = {2'b00, out_mag, job_r.zoom_position, job_r.low_nibble, job_r.kind};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      vrzd_pkg::ST_IDLE: if (job_valid) begin
        st_nxt = (job.kind == vrzd_pkg::KIND_POS) ? vrzd_pkg::ST_SCAN : vrzd_pkg::ST_OUT;
      end
      vrzd_pkg::ST_SCAN: begin
        if (zp <= pf || zp >= pl) st_nxt = vrzd_pkg::ST_OUT;
        else if (zp >= p0 && zp <= p1) begin
          st_nxt = (p1 == p0) ? vrzd_pkg::ST_OUT : vrzd_pkg::ST_MUL;
        end else if (IW'(idx_r + IW'(1)) >= last_idx) st_nxt = vrzd_pkg::ST_OUT;
      end
      vrzd_pkg::ST_MUL: st_nxt = vrzd_pkg::ST_DIV;
      vrzd_pkg::ST_DIV: if (bit_r == 5'd0) st_nxt = vrzd_pkg::ST_OUT;
      vrzd_pkg::ST_OUT: if (out_tready) st_nxt = vrzd_pkg::ST_IDLE;
      default: st_nxt = vrzd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= vrzd_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      vrzd_pkg::ST_IDLE: begin
        job_r <= job;
        idx_r <= '0;
        mag_r <= 16'd0;
      end
      vrzd_pkg::ST_SCAN: begin
        if (zp <= pf) mag_r <= mf;
        else if (zp >= pl) mag_r <= ml;
        else if (zp >= p0 && zp <= p1) begin
          pdiff_r <= zp - p0;
          neg_r <= (m1 < m0);
          num_r <= (m1 < m0) ? (m0 - m1) : (m1 - m0);
          den_r <= p1 - p0;
          mag_r <= m0;
        end else if (IW'(idx_r + IW'(1)) >= last_idx) mag_r <= ml;
        else idx_r <= IW'(idx_r + IW'(1));
      end
      vrzd_pkg::ST_MUL: begin
        dividend_r <= 32'(pdiff_r) * 32'(num_r);
        rem_r <= '0;
        q_r <= '0;
        bit_r <= 5'd31;
      end
      vrzd_pkg::ST_DIV: begin
        rem_r <= trial[17] ? {rem_r[14:0], dividend_r[31]} : trial[15:0];
        q_r <= q_step;
        dividend_r <= {dividend_r[30:0], 1'b0};
        bit_r <= bit_r - 5'd1;
        if (bit_r == 5'd0) mag_r <= neg_r ? (mag_r - q_step) : (mag_r + q_step);
      end
      vrzd_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== design/vrzd_checker.sv =====
`timescale 1ns / 1ps
`include "visca_reply_zoom_decoder_macros.svh"
module vrzd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  logic non_pos;

  assign non_pos = out_tvalid && (out_tdata[1:0] != vrzd_pkg::KIND_POS);

  `VRZ_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `VRZ_ASSERT_IMPL(a_zero_pos, clk, rst_n, non_pos, out_tdata[39:6] == 34'd0)
  `VRZ_ASSERT_IMPL(a_pad, clk, rst_n, out_tvalid, out_tdata[39:38] == 2'b00)
endmodule

bind visca_reply_zoom_decoder vrzd_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

// ===== verif/tb_visca_reply_zoom_decoder.sv =====
`timescale 1ns / 1ps
module tb_visca_reply_zoom_decoder;

  typedef struct {
    logic [7:0] data_byte;
    logic [7:0] source_id;
    logic       eop;
  } reply_byte_t;

  typedef struct {
    vrzd_pkg::kind_t kind;
    logic [3:0]  low_nibble;
    logic [15:0] zoom_position;
    logic [15:0] magnification;
  } reply_t;

  localparam int StallLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  visca_reply_zoom_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder shadow state
  logic [7:0]  m_target_id;
  logic [3:0]  m_point_count;
  logic [63:0] m_pos [3];
  logic [63:0] m_mag [3];
  logic [3:0]  m_count;
  logic        m_src_ok;
  logic        m_head_ok;
  logic [7:0]  m_second;
  logic        m_clean;
  logic [15:0] m_position;

  reply_byte_t byte_queue [$];
  reply_t      reply_queue [$];
  int          errors;
  int          stall_cycles;
  int          sent_bytes;
  bit          hold_sender;
  logic        in_taken;
  int          send_wait;
  int          recv_wait;

  function automatic logic [15:0] curve_field(input logic [63:0] regs [3], input int k);
    return regs[k / 4][16 * (k % 4) +: 16];
  endfunction

  function automatic logic [15:0] zoom_to_mag(input logic [15:0] p);
    int n;
    longint p0;
    longint p1;
    longint m0;
    longint m1;
    n = int'(m_point_count);
    if (n < 2) n = 2;
    if (n > vrzd_pkg::MaxCurvePoints) n = vrzd_pkg::MaxCurvePoints;
    if (p <= curve_field(m_pos, 0)) return curve_field(m_mag, 0);
    if (p >= curve_field(m_pos, n - 1)) return curve_field(m_mag, n - 1);
    for (int i = 0; i + 1 < n; i++) begin
      p0 = curve_field(m_pos, i);
      p1 = curve_field(m_pos, i + 1);
      if (p >= p0 && p <= p1) begin
        m0 = curve_field(m_mag, i);
        m1 = curve_field(m_mag, i + 1);
        if (p1 - p0 <= 0) return m0[15:0];
        return 16'(m0 + ((longint'(p) - p0) * (m1 - m0)) / (p1 - p0));
      end
    end
    return curve_field(m_mag, n - 1);
  endfunction

  function automatic void clear_packet();
    m_count = '0;
    m_src_ok = 1'b0;
    m_head_ok = 1'b0;
    m_second = '0;
    m_clean = 1'b1;
    m_position = '0;
  endfunction

  task automatic decode_byte(input reply_byte_t item);
    reply_t r;
    logic [3:0] hi;
    bit hit;
    hit = 1'b0;
    if (m_count == 4'd0) begin
      m_src_ok = (item.source_id == m_target_id);
      m_head_ok = (item.data_byte == vrzd_pkg::HeadByte);
    end else if (m_count == 4'd1) begin
      m_second = item.data_byte;
    end else if (m_count <= 4'd5) begin
      if (item.data_byte[7:4] != 4'd0) m_clean = 1'b0;
      m_position = {m_position[11:0], item.data_byte[3:0]};
    end
    if (m_count < 4'd15) m_count++;
    if (!item.eop) return;
    hi = m_second[7:4];
    r.kind = vrzd_pkg::KIND_ACK;
    r.low_nibble = m_second[3:0];
    r.zoom_position = '0;
    r.magnification = '0;
    if (m_src_ok && m_count >= 4'd3 && m_head_ok && item.data_byte == vrzd_pkg::TailByte) begin
      if (hi == vrzd_pkg::HiAck) begin
        r.kind = vrzd_pkg::KIND_ACK;
        hit = 1'b1;
      end else if (hi == vrzd_pkg::HiComp && m_count == 4'd3) begin
        r.kind = vrzd_pkg::KIND_COMP;
        hit = 1'b1;
      end else if (hi == vrzd_pkg::HiComp && m_count == 4'd7 && m_clean) begin
        r.kind = vrzd_pkg::KIND_POS;
        r.zoom_position = m_position;
        r.magnification = zoom_to_mag(m_position);
        hit = 1'b1;
      end else if (hi == vrzd_pkg::HiErr) begin
        r.kind = vrzd_pkg::KIND_ERR;
        hit = 1'b1;
      end
    end
    clear_packet();
    if (hit) reply_queue.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n || hold_sender) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
    end else if (send_wait > 0) begin
      in_tvalid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (byte_queue.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= {byte_queue[0].source_id, byte_queue[0].data_byte};
      in_tlast <= byte_queue[0].eop;
      send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      out_tready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready)
        recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (cfg_valid && cfg_ready) || (out_tvalid && out_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (in_tvalid && in_tready) begin
        decode_byte(byte_queue.pop_front());
        sent_bytes <= sent_bytes + 1;
      end
      if (out_tvalid && out_tready) begin
        if (reply_queue.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          errors++;
        end else begin
          reply_t e;
          e = reply_queue.pop_front();
          if (out_tdata[1:0] != e.kind) begin
            $error("reply_kind: expected %0d, actual %0d", e.kind, out_tdata[1:0]);
            errors++;
          end
          if (out_tdata[5:2] != e.low_nibble) begin
            $error("low_nibble: expected %0d, actual %0d", e.low_nibble, out_tdata[5:2]);
            errors++;
          end
          if (out_tdata[21:6] != e.zoom_position) begin
            $error("zoom_position: expected %0d, actual %0d", e.zoom_position,
                   out_tdata[21:6]);
            errors++;
          end
          if (out_tdata[37:22] != e.magnification) begin
            $error("magnification: expected %0d, actual %0d", e.magnification,
                   out_tdata[37:22]);
            errors++;
          end
        end
      end
      if (stall_cycles >= StallLimit) begin
        $display("tb_visca_reply_zoom_decoder: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input vrzd_pkg::cfg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      vrzd_pkg::CFG_TARGET_ID: m_target_id = value[7:0];
      vrzd_pkg::CFG_COUNT:     m_point_count = value[3:0];
      vrzd_pkg::CFG_POS_LOW:   m_pos[0] = value;
      vrzd_pkg::CFG_POS_MID:   m_pos[1] = value;
      vrzd_pkg::CFG_POS_HIGH:  m_pos[2] = value;
      vrzd_pkg::CFG_MAG_LOW:   m_mag[0] = value;
      vrzd_pkg::CFG_MAG_MID:   m_mag[1] = value;
      vrzd_pkg::CFG_MAG_HIGH:  m_mag[2] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || reply_queue.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic [7:0] sid, input logic eop);
    reply_byte_t item;
    item.data_byte = b;
    item.source_id = sid;
    item.eop = eop;
    byte_queue.push_back(item);
  endtask

  // well-formed packet with random content, occasionally broken
  task automatic push_packet(input int len, input logic [7:0] second, input bit clean);
    logic [7:0] sid;
    logic [7:0] b;
    sid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : m_target_id;
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : vrzd_pkg::HeadByte;
      else if (i == 1) b = second;
      else if (i == len - 1) b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : vrzd_pkg::TailByte;
      else if (i <= 5) b = clean ? {4'h0, 4'($urandom)} : 8'($urandom);
      else b = 8'($urandom);
      push_byte(b, (i == 0) ? sid : 8'($urandom), i == len - 1);
    end
  endtask

  task automatic random_curve(input bit ordered);
    logic [15:0] p;
    p = '0;
    for (int r = 0; r < 3; r++) begin
      logic [63:0] pv;
      logic [63:0] mv;
      for (int k = 0; k < 4; k++) begin
        if (ordered) begin
          if (16'hFFFF - p > 16'h1800) p = p + 16'($urandom_range(0, 16'h1800));
          pv[16 * k +: 16] = p;
        end else begin
          pv[16 * k +: 16] = 16'($urandom);
        end
        mv[16 * k +: 16] = 16'($urandom);
      end
      m_pos[r] = pv;
      m_mag[r] = mv;
    end
    write_reg(vrzd_pkg::CFG_POS_LOW, m_pos[0]);
    write_reg(vrzd_pkg::CFG_POS_MID, m_pos[1]);
    write_reg(vrzd_pkg::CFG_POS_HIGH, m_pos[2]);
    write_reg(vrzd_pkg::CFG_MAG_LOW, m_mag[0]);
    write_reg(vrzd_pkg::CFG_MAG_MID, m_mag[1]);
    write_reg(vrzd_pkg::CFG_MAG_HIGH, m_mag[2]);
  endtask

  task automatic random_phase(input int nbytes);
    int pick;
    logic [7:0] second;
    while (sent_bytes < nbytes) begin
      pick = $urandom_range(0, 9);
      second = {4'($urandom_range(4, 6)), 4'($urandom)};
      if (pick <= 3) push_packet(7, {vrzd_pkg::HiComp, 4'($urandom)}, 1'b1);
      else if (pick <= 5) push_packet(3, second, 1'b1);
      else if (pick == 6) push_packet($urandom_range(3, 7), second, 1'($urandom_range(0, 1)));
      else if (pick == 7) push_packet($urandom_range(1, 18), 8'($urandom), 1'b0);
      else push_packet($urandom_range(3, 9), second, 1'b1);
      while (byte_queue.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = vrzd_pkg::CFG_TARGET_ID;
    cfg_data = '0;
    errors = 0;
    stall_cycles = 0;
    sent_bytes = 0;
    hold_sender = 1'b0;
    send_wait = 0;
    recv_wait = 0;
    m_target_id = 8'd11;
    m_point_count = 4'd10;
    m_pos[0] = 64'd2938356911949873152;
    m_pos[1] = 64'd4351948069680263595;
    m_pos[2] = 64'd1073757825;
    m_mag[0] = 64'd288233674720149760;
    m_mag[1] = 64'd576468448985482496;
    m_mag[2] = 64'd167774464;
    clear_packet();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset curve, every kind, extremes
    push_byte(vrzd_pkg::HeadByte, 8'd11, 1'b0);
    push_byte(8'h41, 8'd0, 1'b0);
    push_byte(vrzd_pkg::TailByte, 8'd0, 1'b1);
    push_byte(vrzd_pkg::HeadByte, 8'd11, 1'b0);
    push_byte(8'h5F, 8'd0, 1'b0);
    push_byte(vrzd_pkg::TailByte, 8'd0, 1'b1);
    push_byte(vrzd_pkg::HeadByte, 8'd11, 1'b0);
    push_byte(8'h6A, 8'd0, 1'b0);
    push_byte(vrzd_pkg::TailByte, 8'd0, 1'b1);
    push_byte(vrzd_pkg::HeadByte, 8'd11, 1'b0);
    push_byte(8'h50, 8'hFF, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(8'h0F, 8'hFF, 1'b0);
    push_byte(vrzd_pkg::TailByte, 8'hFF, 1'b1);
    push_byte(vrzd_pkg::HeadByte, 8'd11, 1'b0);
    push_byte(8'h51, 8'd0, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(8'h00, 8'd0, 1'b0);
    push_byte(vrzd_pkg::TailByte, 8'd0, 1'b1);
    push_byte(vrzd_pkg::HeadByte, 8'd11, 1'b0);
    push_byte(8'h51, 8'd0, 1'b0);
    push_byte(8'hF3, 8'd0, 1'b0);
    push_byte(8'h02, 8'd0, 1'b0);
    push_byte(8'h07, 8'd0, 1'b0);
    push_byte(8'h01, 8'd0, 1'b0);
    push_byte(vrzd_pkg::TailByte, 8'd0, 1'b1);
    drain();

    // extremes of the configuration
    write_reg(vrzd_pkg::CFG_TARGET_ID, 64'hFF);
    write_reg(vrzd_pkg::CFG_COUNT, 64'd0);
    random_curve(1'b1);
    random_phase(300);
    drain();
    write_reg(vrzd_pkg::CFG_TARGET_ID, 64'h00);
    write_reg(vrzd_pkg::CFG_COUNT, 64'd15);
    random_curve(1'b1);
    random_phase(650);
    drain();
    write_reg(vrzd_pkg::CFG_COUNT, 64'(vrzd_pkg::MaxCurvePoints));
    write_reg(vrzd_pkg::CFG_POS_LOW, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(vrzd_pkg::CFG_MAG_LOW, 64'hFFFF_0000_FFFF_0000);
    random_phase(900);

    // pause until every pending result is out
    while (byte_queue.size() > 0) @(posedge clk);
    hold_sender = 1'b1;
    while (reply_queue.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    for (int s = 0; s < 4; s++) begin
      write_reg(vrzd_pkg::CFG_TARGET_ID, 64'(8'($urandom)));
      write_reg(vrzd_pkg::CFG_COUNT, 64'($urandom_range(2, 12)));
      random_curve(1'(s % 2));
      random_phase(900 + 220 * (s + 1));
      drain();
    end

    if (errors == 0) begin
      $display("tb_visca_reply_zoom_decoder: PASS");
    end else begin
      $display("tb_visca_reply_zoom_decoder: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/vrzd_pkg.sv
design/vrzd_front.sv
design/vrzd_back.sv
design/visca_reply_zoom_decoder.sv
design/vrzd_checker.sv
verif/tb_visca_reply_zoom_decoder.sv
